[rtl/core/kgr_pkg.sv]
// ---------------------------------------------------------------------------
// kgr_pkg: shared types and constants for the group reverse reorder block
// Command and status bundles between controller and datapath, field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package kgr_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 5;

  localparam logic [CfgW-1:0] GroupSizeReset = 5'd2;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // take the input item, write it into the buffer
    logic issue;   // read the next buffered value toward the output
  } kgr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit_needed;  // current input completes a group or ends the sequence
    logic out_free;     // output register can take a new value this cycle
    logic last_read;    // the pending read is the final one of the burst
  } kgr_stat_t;

endpackage

`default_nettype wire

[rtl/core/kgr_ram.sv]
// ---------------------------------------------------------------------------
// kgr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ---------------------------------------------------------------------------
`default_nettype none

module kgr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/kgr_ctrl.sv]
// ---------------------------------------------------------------------------
// kgr_ctrl: sequencing controller
// Alternates between collecting items and draining a burst from the buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module kgr_ctrl
  import kgr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire kgr_stat_t stat_i,
  output      kgr_cmd_t  cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.issue  = 1'b0;
    case (state_q)
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.emit_needed) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        // advance one read whenever the output register frees up
        cmd_o.issue = stat_i.out_free;
        if (stat_i.out_free && stat_i.last_read) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

`default_nettype wire

[rtl/core/kgr_dp.sv]
// ---------------------------------------------------------------------------
// kgr_dp: group buffer datapath
// Holds the group size, fill count, buffer RAM, burst index and output flags.
// ---------------------------------------------------------------------------
`default_nettype none

module kgr_dp
  import kgr_pkg::*;
#(
  parameter int unsigned MaxGroup = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  input  wire logic [DataW-1:0] value_i,
  input  wire logic             seq_end_i,
  input  wire kgr_cmd_t         cmd_i,
  output      kgr_stat_t        stat_o,
  output      logic [DataW-1:0] out_value_o,
  output      logic             out_valid_o,
  output      logic             out_run_last_o,
  output      logic             out_seq_end_o,
  input  wire logic             out_stall_i
);

  localparam int unsigned AddrW = $clog2(MaxGroup);
  localparam int unsigned CntW  = $clog2(MaxGroup + 1);
  localparam int unsigned KW    = (CntW > CfgW) ? CntW : CfgW;

  logic [CfgW-1:0]  group_size_q;
  logic [AddrW-1:0] fill_q;
  logic [CntW-1:0]  n_q;
  logic [AddrW-1:0] idx_q;
  logic             rev_q, end_q;
  logic             out_valid_q, out_last_q, out_end_q;

  logic [KW-1:0]    gs_ext, k_eff, n_new_ext;
  logic [CntW-1:0]  n_new;
  logic             full_grp;
  logic             out_taken;
  logic [CntW-1:0]  rev_addr;
  logic [AddrW-1:0] raddr;

  // clamp the group size into 1..MaxGroup
  always_comb begin
    gs_ext = KW'(group_size_q);
    if (gs_ext == '0) begin
      k_eff = KW'(1);
    end else if (gs_ext > KW'(MaxGroup)) begin
      k_eff = KW'(MaxGroup);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign n_new     = CntW'(fill_q) + CntW'(1);
  assign n_new_ext = KW'(n_new);
  assign full_grp  = (n_new_ext >= k_eff);

  assign out_taken = out_valid_q && !out_stall_i;
  assign rev_addr  = n_q - CntW'(1) - CntW'(idx_q);
  assign raddr     = rev_q ? rev_addr[AddrW-1:0] : idx_q;

  assign stat_o.emit_needed = full_grp || seq_end_i;
  assign stat_o.out_free    = !out_valid_q || out_taken;
  assign stat_o.last_read   = (CntW'(idx_q) == (n_q - CntW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GroupSizeReset;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        fill_q <= (full_grp || seq_end_i) ? '0 : n_new[AddrW-1:0];
      end
      if (cmd_i.issue) begin
        out_valid_q <= 1'b1;
      end else if (out_taken) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // burst bookkeeping, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      n_q   <= n_new;
      rev_q <= full_grp;
      end_q <= seq_end_i;
      idx_q <= '0;
    end else if (cmd_i.issue) begin
      idx_q <= idx_q + AddrW'(1);
    end
    if (cmd_i.issue) begin
      out_last_q <= stat_o.last_read;
      out_end_q  <= stat_o.last_read && end_q;
    end
  end

  kgr_ram #(
    .Width (DataW),
    .Depth (MaxGroup)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (fill_q),
    .wdata_i (value_i),
    .re_i    (cmd_i.issue),
    .raddr_i (raddr),
    .rdata_o (out_value_o)
  );

  assign out_valid_o    = out_valid_q;
  assign out_run_last_o = out_last_q;
  assign out_seq_end_o  = out_end_q;

endmodule

`default_nettype wire

[rtl/core/k_group_reverse_reorder.sv]
// ---------------------------------------------------------------------------
// k_group_reverse_reorder: reverse a value stream in groups of group_size
// Buffers items, then replays each full group reversed and a trailing
// partial group in arrival order.
// ---------------------------------------------------------------------------
// Items are collected one per cycle into a MAX_GROUP deep buffer RAM. An item
// that completes a group (held count reaches the clamped group size) or that
// carries seq_end starts a burst: the input stalls while the held values are
// read back through the RAM's registered read port, which doubles as the
// output register, one per cycle unless the output stalls. The input is open
// again once the last read of a burst is issued, even while that last result
// still waits downstream. group_size is a 5-bit register (reset 2); zero acts
// as 1 and values above MAX_GROUP act as MAX_GROUP. Write it only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module k_group_reverse_reorder
  import kgr_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  // input channel
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [31:0] value_i,
  input  wire logic               seq_end_i,
  // output channel
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] out_value_o,
  output      logic               out_run_last_o,
  output      logic               out_seq_end_o
);

  kgr_cmd_t         cmd;
  kgr_stat_t        stat;
  logic [DataW-1:0] rd_value;

  // sequencing: collect, then drain
  kgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // buffer, counters and output register
  kgr_dp #(
    .MaxGroup (MAX_GROUP)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .value_i        (DataW'(value_i)),
    .seq_end_i      (seq_end_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_value_o    (rd_value),
    .out_valid_o    (out_valid_o),
    .out_run_last_o (out_run_last_o),
    .out_seq_end_o  (out_seq_end_o),
    .out_stall_i    (out_stall_i)
  );

  assign out_value_o = signed'(rd_value);

  // reads happen only during a burst, while the input is held off
  a_issue_in_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> in_stall_o)
    else $error("buffer read issued outside a burst");

  // an item that finishes a group or sequence must start a burst
  a_burst_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && stat.emit_needed) |=> (in_stall_o && out_valid_o == $past(out_valid_o
      && out_stall_i)) || in_stall_o)
    else $error("burst did not start after completing item");

  // sequence end is flagged only on the last result of a burst
  a_end_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_seq_end_o) |-> out_run_last_o)
    else $error("sequence end flagged on a non-final result");

  // an item that neither completes a group nor ends the sequence starts no burst
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && !stat.emit_needed) |=> !in_stall_o)
    else $error("burst started without a completing item");

endmodule

`default_nettype wire

[verif/kgr_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kgr_checker: scoreboard for the group reverse reorder block
// Watches the configuration port and both item channels, predicts each
// reordered item and compares every accepted output item field by field.
// ---------------------------------------------------------------------------
module kgr_checker
  import kgr_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CfgW-1:0]  cfg_wdata_i,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire logic [DataW-1:0] value_i,
  input  wire logic             seq_end_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_stall_i,
  input  wire logic [DataW-1:0] out_value_i,
  input  wire logic             out_run_last_i,
  input  wire logic             out_seq_end_i,
  output int                    pending_o,
  output int                    errors_o
);

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             run_last;
    logic             seq_end;
  } reorder_item_t;

  reorder_item_t    reordered_q[$];
  logic [DataW-1:0] held_vals [MAX_GROUP];
  int unsigned      held_cnt;
  logic [CfgW-1:0]  group_len;
  int               fail_cnt = 0;

  function automatic int unsigned clamp_len(logic [CfgW-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_GROUP) return MAX_GROUP;
    return 32'(raw);
  endfunction

  // Append one value; on a full group or on seq_end, queue the held values.
  task automatic reorder_item(logic [DataW-1:0] v, logic e);
    int unsigned   k;
    int unsigned   n;
    int unsigned   i;
    reorder_item_t r;
    k = clamp_len(group_len);
    if (held_cnt >= MAX_GROUP) held_cnt = MAX_GROUP - 1;
    held_vals[held_cnt] = v;
    held_cnt++;
    n = held_cnt;
    if (n >= k || e) begin
      for (i = 0; i < n; i++) begin
        r.value    = (n >= k) ? held_vals[n - 1 - i] : held_vals[i];
        r.run_last = (i == n - 1);
        r.seq_end  = (i == n - 1) && e;
        reordered_q.insert(reordered_q.size(), r);
      end
      held_cnt = 0;
    end
  endtask

  task automatic check_item();
    reorder_item_t want;
    if (reordered_q.size() == 0) begin
      $display("%0t: unexpected item: expected none, actual value %h last %b end %b",
               $time, out_value_i, out_run_last_i, out_seq_end_i);
      fail_cnt++;
      return;
    end
    want = reordered_q.pop_front();
    if (out_value_i !== want.value) begin
      $display("%0t: out_value expected %h actual %h", $time, want.value, out_value_i);
      fail_cnt++;
    end
    if (out_run_last_i !== want.run_last) begin
      $display("%0t: run_last expected %b actual %b", $time, want.run_last, out_run_last_i);
      fail_cnt++;
    end
    if (out_seq_end_i !== want.seq_end) begin
      $display("%0t: out_seq_end expected %b actual %b", $time, want.seq_end, out_seq_end_i);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt  = 0;
      group_len = GroupSizeReset;
      reordered_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // outputs of this edge stem from earlier items, so check them first
      if (out_valid_i && !out_stall_i) check_item();
      // an item taken at this edge still sees the old group size
      if (in_valid_i && !in_stall_i) reorder_item(value_i, seq_end_i);
      if (cfg_we_i) group_len = cfg_wdata_i;
      pending_o <= reordered_q.size();
      errors_o  <= fail_cnt;
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for k_group_reverse_reorder
// Drives directed and random value sequences under several group sizes,
// with random idle cycles on both channels; a checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_top
  import kgr_pkg::*;
;

  localparam int unsigned MaxGroup    = 16;
  localparam int unsigned RandomItems = 449;
  localparam int unsigned DrainCycles = 4;     // covers the last buffer write
  localparam int unsigned QuietLimit  = 1000;  // cycles with no item moving

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [CfgW-1:0]  cfg_wdata  = '0;
  logic             in_valid   = 1'b0;
  logic [DataW-1:0] in_value   = '0;
  logic             in_seq_end = 1'b0;
  logic             out_stall  = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [DataW-1:0] out_value;
  logic             out_run_last;
  logic             out_seq_end;
  int               pending;
  int               errors;
  bit               calm = 1'b0;     // suppress idling on both sides
  int unsigned      quiet_cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  k_group_reverse_reorder #(
    .MAX_GROUP(MaxGroup)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .value_i       (in_value),
    .seq_end_i     (in_seq_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_value_o   (out_value),
    .out_run_last_o(out_run_last),
    .out_seq_end_o (out_seq_end)
  );

  kgr_checker #(
    .MAX_GROUP(MaxGroup)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .value_i       (in_value),
    .seq_end_i     (in_seq_end),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_value_i   (out_value),
    .out_run_last_i(out_run_last),
    .out_seq_end_i (out_seq_end),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  // Receiver: stall with a chance of 6 in 100, never during the calm stretch.
  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 6);
  end

  // Watchdog: end the run when no item moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL k_group_reverse_reorder");
      $finish;
    end
  end

  // Offer one item, with optional idle cycles first; hold it until accepted.
  task automatic send_item(input logic [DataW-1:0] v, input logic e);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    in_value   <= v;
    in_seq_end <= e;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Wait until every predicted item has come out, then let the block settle.
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the group size only once the block is idle.
  task automatic write_group_size(input logic [CfgW-1:0] raw);
    in_valid <= 1'b0;
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      k;
    int unsigned      nseq;
    int unsigned      len;
    int unsigned      s;
    int unsigned      j;
    logic [CfgW-1:0]  raw;
    logic [DataW-1:0] v;
    logic             e;
    bit               closed;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset group size of 2: extremes swapped as a pair
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    // full group on the final element
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    // partial group of one closed by seq_end
    send_item(32'h0000_0005, 1'b1);

    // pass-through with size 1 and with size 0
    write_group_size(5'd1);
    send_item(32'h1234_5678, 1'b0);
    send_item(32'hCAFE_0001, 1'b1);
    write_group_size(5'd0);
    send_item(32'h0F0F_0F0F, 1'b0);
    send_item(32'hF0F0_F0F0, 1'b1);

    // partial group emitted in arrival order
    write_group_size(5'd4);
    send_item(32'h0000_0011, 1'b0);
    send_item(32'h0000_0022, 1'b0);
    send_item(32'h0000_0033, 1'b1);

    // lower the size while a group is held: the whole hold comes out reversed
    write_group_size(5'd5);
    send_item(32'hA000_0001, 1'b0);
    send_item(32'hA000_0002, 1'b0);
    send_item(32'hA000_0003, 1'b0);
    write_group_size(5'd2);
    send_item(32'hA000_0004, 1'b0);

    // raise the size while a group is held
    write_group_size(5'd3);
    send_item(32'hB000_0001, 1'b0);
    write_group_size(5'd6);
    send_item(32'hB000_0002, 1'b0);
    send_item(32'hB000_0003, 1'b1);

    // size above the buffer depth saturates; short sequence ends partial
    write_group_size(5'd31);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b1);

    // Random part: mostly well-formed sequences, some cut short or with
    // stray seq_end, under a fresh group size per segment.
    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 9))
        6:       raw = 5'd0;
        7:       raw = 5'd16;
        8:       raw = 5'($urandom_range(17, 31));
        9:       raw = 5'($urandom_range(6, 15));
        default: raw = 5'($urandom_range(1, 5));
      endcase
      write_group_size(raw);
      k = (raw == 0) ? 1 : ((raw > MaxGroup) ? MaxGroup : 32'(raw));
      nseq = $urandom_range(1, 3);
      for (s = 0; s < nseq; s++) begin
        len    = $urandom_range(1, 3 * k + 2);
        closed = ($urandom_range(0, 99) < 85);
        for (j = 0; j < len && sent < RandomItems; j++) begin
          v = $urandom;
          if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
              0:       v = 32'h8000_0000;
              1:       v = 32'h7FFF_FFFF;
              2:       v = 32'h0000_0000;
              default: v = 32'hFFFF_FFFF;
            endcase
          end
          e = ((j == len - 1) && closed) || ($urandom_range(0, 19) == 0);
          send_item(v, e);
          sent++;
          calm = (sent >= 150) && (sent < 260);
        end
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("PASS k_group_reverse_reorder");
    end else begin
      $display("FAIL k_group_reverse_reorder");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/kgr_pkg.sv
rtl/core/kgr_ram.sv
rtl/core/kgr_ctrl.sv
rtl/core/kgr_dp.sv
rtl/core/k_group_reverse_reorder.sv
verif/kgr_checker.sv
verif/tb_top.sv
